// ===== src/lfc_pkg.sv =====
// Shared types and constants of the linear fan curve controller.
package lfc_pkg;

    localparam int TEMP_BITS  = 12;
    localparam int DUTY_BITS  = 8;
    localparam int IVAL_BITS  = 16;
    localparam int CFG_BITS   = 16;
    localparam int ADDR_BITS  = 3;
    localparam int DIV_STEPS  = DUTY_BITS;
    localparam int DIV_W      = TEMP_BITS + DUTY_BITS;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
    localparam logic [DUTY_BITS-1:0] DUTY_MIN = '0;
    localparam logic [IVAL_BITS-1:0] ELAPSED_SAT = {IVAL_BITS{1'b1}};

    localparam logic [ADDR_BITS-1:0] CFG_UPDATE_INTERVAL  = 3'd0;
    localparam logic [ADDR_BITS-1:0] CFG_OFF_TEMPERATURE  = 3'd1;
    localparam logic [ADDR_BITS-1:0] CFG_FULL_TEMPERATURE = 3'd2;
    localparam logic [ADDR_BITS-1:0] CFG_OVERRIDE_ENABLE  = 3'd3;
    localparam logic [ADDR_BITS-1:0] CFG_MANUAL_DUTY      = 3'd4;

    localparam logic [IVAL_BITS-1:0] RST_UPDATE_INTERVAL = 16'd2000;
    localparam logic [TEMP_BITS-1:0] RST_OFF_TEMPERATURE = 12'd480;
    localparam logic [TEMP_BITS-1:0] RST_FULL_TEMPERATURE = 12'd800;
    localparam logic [DUTY_BITS-1:0] RST_MANUAL_DUTY = 8'd255;

    typedef struct packed {
        logic                        sample_valid;
        logic signed [TEMP_BITS-1:0] temperature;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_BITS-1:0] fan_duty;
        logic                 duty_updated;
    } t_out_item;

endpackage

// ===== src/linear_fan_curve_controller_top.sv =====
// Top level of the linear fan curve controller: registers, sequencer, output stage.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_ready   i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_ready o_out_item (t_out_item)
//   cfg       input      i_cfg_wr_en               i_cfg_addr, i_cfg_wdata
//
// An item that needs no curve division has its result registered in the cycle after acceptance.
// An item that runs the curve goes through load, 8 passes of the shared subtractor
// in the serial divider, and write-back.
// Reset sets the counter to saturation, so the first valid sample updates at once.
// The input is not ready while a division runs or a result waits in the output register.
module linear_fan_curve_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lfc_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lfc_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_wr_en,
    input  logic [lfc_pkg::ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [lfc_pkg::CFG_BITS-1:0]   i_cfg_wdata
);
    import lfc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state                      r_state;
    logic [IVAL_BITS-1:0]        r_update_interval;
    logic signed [TEMP_BITS-1:0] r_off_temperature;
    logic signed [TEMP_BITS-1:0] r_full_temperature;
    logic                        r_override_enable;
    logic [DUTY_BITS-1:0]        r_manual_duty;
    logic [DUTY_BITS-1:0]        r_held_duty;
    logic [IVAL_BITS-1:0]        r_elapsed_ms;
    logic                        r_out_valid;
    t_out_item                   r_out_item;

    logic                        w_accept;
    logic [IVAL_BITS-1:0]        n_elapsed_ms;
    logic                        w_due;
    logic                        w_degen;
    logic [TEMP_BITS-1:0]        w_delta;
    logic [TEMP_BITS-1:0]        w_span;
    logic [DIV_W-1:0]            w_num;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [DUTY_BITS-1:0]        w_div_quot;
    logic                        w_out_load;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign n_elapsed_ms = (r_elapsed_ms == ELAPSED_SAT) ? ELAPSED_SAT
                                                        : r_elapsed_ms + 1'b1;
    assign w_due   = i_in_item.sample_valid && (n_elapsed_ms >= r_update_interval);
    assign w_degen = (r_full_temperature <= r_off_temperature);
    assign w_delta = TEMP_BITS'(i_in_item.temperature - r_off_temperature);
    assign w_span  = TEMP_BITS'(r_full_temperature - r_off_temperature);
    assign w_num   = DIV_W'({w_delta, {DUTY_BITS{1'b0}}}) - DIV_W'(w_delta);

    assign w_div_start = w_accept && !r_override_enable && w_due && !w_degen
                         && (i_in_item.temperature > r_off_temperature)
                         && (i_in_item.temperature < r_full_temperature);

    assign w_out_load = (w_accept && !w_div_start) || ((r_state == S_DIV) && w_div_done);

    lfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_span),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_interval  <= RST_UPDATE_INTERVAL;
            r_off_temperature  <= RST_OFF_TEMPERATURE;
            r_full_temperature <= RST_FULL_TEMPERATURE;
            r_override_enable  <= 1'b0;
            r_manual_duty      <= RST_MANUAL_DUTY;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_UPDATE_INTERVAL:  r_update_interval  <= i_cfg_wdata[IVAL_BITS-1:0];
                CFG_OFF_TEMPERATURE:  r_off_temperature  <= i_cfg_wdata[TEMP_BITS-1:0];
                CFG_FULL_TEMPERATURE: r_full_temperature <= i_cfg_wdata[TEMP_BITS-1:0];
                CFG_OVERRIDE_ENABLE:  r_override_enable  <= i_cfg_wdata[0];
                CFG_MANUAL_DUTY:      r_manual_duty      <= i_cfg_wdata[DUTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held_duty  <= '0;
            r_elapsed_ms <= ELAPSED_SAT;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_override_enable) begin
                            r_elapsed_ms <= n_elapsed_ms;
                            r_held_duty  <= r_manual_duty;
                            r_out_item   <= '{fan_duty: r_manual_duty, duty_updated: 1'b0};
                        end else if (w_due) begin
                            r_elapsed_ms <= '0;
                            if (w_div_start) begin
                                r_state <= S_DIV;
                            end else if (i_in_item.temperature > r_off_temperature) begin
                                r_held_duty <= DUTY_MAX;
                                r_out_item  <= '{fan_duty: DUTY_MAX, duty_updated: 1'b1};
                            end else begin
                                r_held_duty <= DUTY_MIN;
                                r_out_item  <= '{fan_duty: DUTY_MIN, duty_updated: 1'b1};
                            end
                        end else begin
                            r_elapsed_ms <= n_elapsed_ms;
                            r_out_item   <= '{fan_duty: r_held_duty, duty_updated: 1'b0};
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_held_duty <= w_div_quot;
                        r_out_item  <= '{fan_duty: w_div_quot, duty_updated: 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/lfc_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module lfc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [lfc_pkg::DIV_W-1:0]         i_num,
    input  logic [lfc_pkg::TEMP_BITS-1:0]     i_den,
    output logic                              o_done,
    output logic [lfc_pkg::DUTY_BITS-1:0]     o_quot
);
    import lfc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_dsr;
    logic [DUTY_BITS-1:0] r_quot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 w_ge;

    assign w_ge   = (r_rem >= r_dsr);
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_rem  <= i_num;
                r_dsr  <= DIV_W'({i_den, {(DIV_STEPS-1){1'b0}}});
                r_cnt  <= CNT_W'(DIV_STEPS - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsr;
                end
                r_quot <= {r_quot[DUTY_BITS-2:0], w_ge};
                r_dsr  <= r_dsr >> 1;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule
